// ----- rtl/core/psq_pkg.sv -----
// Package for the priority select queue: sizes, codes, payload structs and the
// command and status structs between the controller and the datapath.
// Depends on nothing; every other file of the block but psq_ram uses it.
`timescale 1ns / 1ps

package psq_pkg;

  // Queue capacity and the widths that follow from it.
  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Field widths of one item.
  localparam int unsigned IMP_W   = 7;
  localparam int unsigned SIZE_W  = 3;
  localparam int unsigned TAG_W   = 8;
  localparam int unsigned ENTRY_W = IMP_W + SIZE_W + TAG_W;

  // Operation codes.
  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_POPPED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  // One request as it arrives on the input ports.
  typedef struct packed {
    op_e                op;
    logic [IMP_W-1:0]   importance;
    logic [SIZE_W-1:0]  item_size;
    logic [TAG_W-1:0]   item_tag;
  } req_t;

  // One result as it leaves on the output ports.
  typedef struct packed {
    status_e            status;
    logic [IMP_W-1:0]   out_importance;
    logic [SIZE_W-1:0]  out_size;
    logic [TAG_W-1:0]   out_tag;
    logic               grid_cleared;
  } rsp_t;

  // One stored queue entry.
  typedef struct packed {
    logic [IMP_W-1:0]   importance;
    logic [SIZE_W-1:0]  size;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SHIFT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the request and reset the walk pointers
    logic insert;      // append the request or report full
    logic empty_pop;   // report a pop on an empty queue
    logic scan;        // one step of the search for the best entry
    logic shift_init;  // point the compaction just behind the best entry
    logic shift;       // one step of moving entries up by one place
    logic finish;      // drop the popped entry and issue the result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_pop;
    logic is_empty;
    logic scan_done;
    logic shift_done;
  } stat_t;

endpackage

// ----- rtl/core/priority_select_queue_top.sv -----
// Top level of the priority select queue: joins the controller and datapath.
// Depends on psq_pkg, psq_ctrl and psq_datapath.
//
// Each request (insert or pop) is taken when start is high and busy is low,
// and gives exactly one result, shown on rsp_o for a single cycle while done_o
// is high. done_o rises in the first cycle in which busy is low again, and a
// new request may be taken in that same cycle; the receiver cannot stall, so
// it must take the result in that cycle. An insert, a pop on an empty queue
// and an insert into a full queue each end after the execute step; a pop on a
// non-empty queue reads the stored entries one per cycle through the single
// read port of the entry RAM, first for the search and then for moving the
// entries younger than the best one up one place.
`timescale 1ns / 1ps

module priority_select_queue_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  psq_pkg::req_t req_i,
  output logic          done_o,
  output psq_pkg::rsp_t rsp_o
);

  psq_pkg::cmd_t  cmd;
  psq_pkg::stat_t stat;

  psq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  psq_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

endmodule

// ----- rtl/core/psq_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered
// read data. Has no dependencies; contents are undefined until written.
`timescale 1ns / 1ps

module psq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                         wr_data_i,
  input  logic                                     rd_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/core/psq_ctrl.sv -----
// Controller of the priority select queue: sequences insert, search and
// compaction steps. Depends on psq_pkg for the state, command and status types.
`timescale 1ns / 1ps

module psq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  output psq_pkg::cmd_t  cmd_o,
  input  psq_pkg::stat_t stat_i
);

  psq_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    case (state_q)
      psq_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = psq_pkg::S_EXEC;
        end
      end
      psq_pkg::S_EXEC: begin
        if (!stat_i.is_pop) begin
          cmd_o.insert = 1'b1;
          state_d      = psq_pkg::S_IDLE;
        end else if (stat_i.is_empty) begin
          cmd_o.empty_pop = 1'b1;
          state_d         = psq_pkg::S_IDLE;
        end else begin
          cmd_o.scan = 1'b1;
          state_d    = psq_pkg::S_SCAN;
        end
      end
      psq_pkg::S_SCAN: begin
        if (stat_i.scan_done) begin
          cmd_o.shift_init = 1'b1;
          state_d          = psq_pkg::S_SHIFT;
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      psq_pkg::S_SHIFT: begin
        if (stat_i.shift_done) begin
          cmd_o.finish = 1'b1;
          state_d      = psq_pkg::S_IDLE;
        end else begin
          cmd_o.shift = 1'b1;
        end
      end
      default: begin
        state_d = psq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/psq_datapath.sv -----
// Datapath of the priority select queue: entry RAM, fill count, search for the
// best entry, compaction and the result register. Depends on psq_pkg, psq_ram.
`timescale 1ns / 1ps

module psq_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  psq_pkg::req_t  req_i,
  input  psq_pkg::cmd_t  cmd_i,
  output psq_pkg::stat_t stat_o,
  output logic           done_o,
  output psq_pkg::rsp_t  rsp_o
);

  localparam int unsigned IdxW = psq_pkg::IDX_W;
  localparam int unsigned CntW = psq_pkg::CNT_W;

  psq_pkg::req_t   req_q;
  logic [CntW-1:0] count_q;
  logic            empty_rep_q;
  logic [CntW-1:0] addr_q;
  logic            pend_q;
  logic [IdxW-1:0] cmp_idx_q;
  logic [IdxW-1:0] best_idx_q;
  psq_pkg::entry_t best_q;
  logic [IdxW-1:0] wr_idx_q;
  psq_pkg::rsp_t   rsp_q;
  logic            done_q;

  logic            full;
  logic            walk;
  logic            rd_en;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  psq_pkg::entry_t wr_data;
  psq_pkg::entry_t rd_entry;
  logic [psq_pkg::ENTRY_W-1:0] rd_data;
  logic            better;

  assign full  = (count_q == CntW'(psq_pkg::QUEUE_DEPTH));
  assign walk  = cmd_i.scan || cmd_i.shift;
  assign rd_en = walk && (addr_q < count_q);

  // Write port: an insert appends, a compaction step moves one entry up.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_q[IdxW-1:0];
    wr_data = '{importance: req_q.importance, size: req_q.item_size, tag: req_q.item_tag};
    if (cmd_i.insert && !full) begin
      wr_en = 1'b1;
    end else if (cmd_i.shift && pend_q) begin
      wr_en   = 1'b1;
      wr_addr = wr_idx_q;
      wr_data = rd_entry;
    end
  end

  psq_ram #(
    .WIDTH (psq_pkg::ENTRY_W),
    .DEPTH (psq_pkg::QUEUE_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (addr_q[IdxW-1:0]),
    .rd_data_o (rd_data)
  );

  assign rd_entry = rd_data;

  // Higher importance wins; equal importance goes to the smaller size.
  assign better = (rd_entry.importance > best_q.importance) ||
                  ((rd_entry.importance == best_q.importance) &&
                   (rd_entry.size < best_q.size));

  // Status back to the controller.
  assign stat_o.is_pop     = (req_q.op == psq_pkg::OP_POP);
  assign stat_o.is_empty   = (count_q == '0);
  assign stat_o.scan_done  = (addr_q == count_q) && !pend_q;
  assign stat_o.shift_done = (addr_q == count_q) && !pend_q;

  // Request capture, walk pointers and search state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q     <= '0;
      pend_q     <= 1'b0;
      cmp_idx_q  <= '0;
      best_idx_q <= '0;
      wr_idx_q   <= '0;
    end else begin
      if (cmd_i.load) begin
        addr_q    <= '0;
        pend_q    <= 1'b0;
        cmp_idx_q <= '0;
      end else if (cmd_i.shift_init) begin
        addr_q   <= CntW'(best_idx_q) + CntW'(1);
        pend_q   <= 1'b0;
        wr_idx_q <= best_idx_q;
      end else if (walk) begin
        pend_q <= rd_en;
        if (rd_en) begin
          addr_q <= addr_q + CntW'(1);
        end
        if (cmd_i.scan && pend_q) begin
          cmp_idx_q <= cmp_idx_q + IdxW'(1);
          if ((cmp_idx_q == '0) || better) begin
            best_idx_q <= cmp_idx_q;
          end
        end
        if (cmd_i.shift && pend_q) begin
          wr_idx_q <= wr_idx_q + IdxW'(1);
        end
      end
    end
  end

  // Payload registers: the captured request and the best entry so far.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.scan && pend_q && ((cmp_idx_q == '0) || better)) begin
      best_q <= rd_entry;
    end
  end

  // Fill count, empty flag and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      empty_rep_q <= 1'b0;
      done_q      <= 1'b0;
      rsp_q       <= '0;
    end else begin
      done_q <= cmd_i.insert || cmd_i.empty_pop || cmd_i.finish;
      if (cmd_i.insert) begin
        if (full) begin
          rsp_q <= '{status: psq_pkg::ST_FULL, out_importance: '0, out_size: '0,
                     out_tag: '0, grid_cleared: 1'b0};
        end else begin
          rsp_q   <= '{status: psq_pkg::ST_INSERTED, out_importance: '0, out_size: '0,
                       out_tag: '0, grid_cleared: 1'b0};
          count_q <= count_q + CntW'(1);
        end
      end else if (cmd_i.empty_pop) begin
        rsp_q       <= '{status: psq_pkg::ST_EMPTY, out_importance: '0, out_size: '0,
                         out_tag: '0, grid_cleared: !empty_rep_q};
        empty_rep_q <= 1'b1;
      end else if (cmd_i.finish) begin
        rsp_q       <= '{status: psq_pkg::ST_POPPED, out_importance: best_q.importance,
                         out_size: best_q.size, out_tag: best_q.tag, grid_cleared: 1'b0};
        count_q     <= count_q - CntW'(1);
        empty_rep_q <= 1'b0;
      end
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // The fill count never passes the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(psq_pkg::QUEUE_DEPTH))
    else $error("psq: fill count above capacity");

  // A popped result removes exactly one entry.
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && rsp_q.status == psq_pkg::ST_POPPED) |->
      count_q == $past(count_q) - CntW'(1))
    else $error("psq: pop did not remove one entry");

  // The cleared flag goes only with an empty pop.
  a_cleared_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && rsp_q.grid_cleared) |-> rsp_q.status == psq_pkg::ST_EMPTY)
    else $error("psq: cleared flag outside an empty pop");

  // A result strobe lasts a single cycle.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("psq: result strobe held for two cycles");

endmodule

// ----- tb/priority_select_queue_top_test.sv -----
// Self-checking testbench for priority_select_queue_top: a driver and a monitor in
// clocked always blocks, checked against a behavioral queue model kept in the bench.
// Depends on psq_pkg and the priority_select_queue_top RTL.
`timescale 1ns / 1ps

module priority_select_queue_top_test;

  localparam int unsigned IMP_MAX     = 100;
  localparam int unsigned SIZE_MAX    = 6;
  localparam int unsigned RANDOM_REQS = 2000;
  localparam int unsigned MAX_GAP     = 10;
  localparam int unsigned SETTLE_CYC  = 48;

  // One request waiting to be sent, with the idle cycles that come before it.
  typedef struct {
    psq_pkg::req_t req;
    int unsigned   gap;
    bit            wait_drain;
  } pending_req_t;

  logic           clk_i  = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start  = 1'b0;
  logic           busy;
  psq_pkg::req_t  req_i  = '0;
  logic           done_o;
  psq_pkg::rsp_t  rsp_o;

  pending_req_t    req_backlog_q[$];
  psq_pkg::rsp_t   predicted_rsp_q[$];
  psq_pkg::entry_t shadow_q[$];
  bit              empty_seen = 1'b0;
  int unsigned     gap_left   = 0;
  int unsigned     fail_count = 0;

  priority_select_queue_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  // 50 MHz clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Applies one request to the shadow queue and returns the result it should give.
  function automatic psq_pkg::rsp_t apply_to_shadow_queue(psq_pkg::req_t r);
    psq_pkg::rsp_t   res;
    psq_pkg::entry_t ent;
    int              best;
    res  = '0;
    best = 0;
    if (r.op == psq_pkg::OP_INSERT) begin
      if (shadow_q.size() >= psq_pkg::QUEUE_DEPTH) begin
        res.status = psq_pkg::ST_FULL;
      end else begin
        ent.importance = r.importance;
        ent.size       = r.item_size;
        ent.tag        = r.item_tag;
        shadow_q.insert(shadow_q.size(), ent);
        res.status = psq_pkg::ST_INSERTED;
      end
    end else if (shadow_q.size() == 0) begin
      // Only the first empty pop since the last successful pop flags the clear.
      res.status       = psq_pkg::ST_EMPTY;
      res.grid_cleared = !empty_seen;
      empty_seen       = 1'b1;
    end else begin
      // Highest importance wins, then smallest size, then the oldest entry.
      for (int i = 1; i < shadow_q.size(); i++) begin
        if (shadow_q[i].importance > shadow_q[best].importance ||
            (shadow_q[i].importance == shadow_q[best].importance &&
             shadow_q[i].size < shadow_q[best].size)) begin
          best = i;
        end
      end
      res.status         = psq_pkg::ST_POPPED;
      res.out_importance = shadow_q[best].importance;
      res.out_size       = shadow_q[best].size;
      res.out_tag        = shadow_q[best].tag;
      shadow_q.delete(best);
      empty_seen = 1'b0;
    end
    return res;
  endfunction

  // Importance values crowd the low end to force ties, and sometimes exceed the range.
  function automatic logic [psq_pkg::IMP_W-1:0] pick_importance();
    case ($urandom_range(0, 7))
      0, 1:    return psq_pkg::IMP_W'($urandom_range(0, 3));
      2:       return psq_pkg::IMP_W'($urandom_range(IMP_MAX + 1, (1 << psq_pkg::IMP_W) - 1));
      3:       return psq_pkg::IMP_W'($urandom_range(0, 1) ? IMP_MAX : 0);
      default: return psq_pkg::IMP_W'($urandom_range(0, IMP_MAX));
    endcase
  endfunction

  // Sizes are mostly legal, sometimes only the two smallest, sometimes any raw value.
  function automatic logic [psq_pkg::SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 7))
      0:       return psq_pkg::SIZE_W'($urandom_range(0, (1 << psq_pkg::SIZE_W) - 1));
      1, 2:    return psq_pkg::SIZE_W'($urandom_range(1, 2));
      default: return psq_pkg::SIZE_W'($urandom_range(1, SIZE_MAX));
    endcase
  endfunction

  task automatic queue_req(psq_pkg::op_e op, logic [psq_pkg::IMP_W-1:0] imp,
                           logic [psq_pkg::SIZE_W-1:0] sz, logic [psq_pkg::TAG_W-1:0] tag,
                           int unsigned gap, bit wait_drain);
    pending_req_t p;
    p.req.op         = op;
    p.req.importance = imp;
    p.req.item_size  = sz;
    p.req.item_tag   = tag;
    p.gap            = gap;
    p.wait_drain     = wait_drain;
    req_backlog_q.insert(req_backlog_q.size(), p);
  endtask

  // Directed requests first, then random episodes that fill, drain or mix the queue.
  task automatic build_stimulus();
    int unsigned  total;
    int unsigned  mode;
    int unsigned  len;
    int unsigned  ins_pct;
    bit           quiet;
    bit           pause;
    psq_pkg::op_e op;
    total = 0;

    // Empty pops on a fresh queue: the first flags the clear, the second does not.
    queue_req(psq_pkg::OP_POP,    0,   0, 8'h00, 0, 1'b0);
    queue_req(psq_pkg::OP_POP,    127, 7, 8'hFF, $urandom_range(0, MAX_GAP), 1'b0);
    // Field extremes, full ties on importance and size, and out-of-range values.
    queue_req(psq_pkg::OP_INSERT, 0,   1, 8'h00, $urandom_range(0, MAX_GAP), 1'b0);
    queue_req(psq_pkg::OP_INSERT, 100, 6, 8'hFF, 0, 1'b0);
    queue_req(psq_pkg::OP_INSERT, 100, 2, 8'hAA, 0, 1'b0);
    queue_req(psq_pkg::OP_INSERT, 100, 2, 8'h55, $urandom_range(0, MAX_GAP), 1'b0);
    queue_req(psq_pkg::OP_INSERT, 127, 0, 8'h0F, 0, 1'b0);
    queue_req(psq_pkg::OP_INSERT, 127, 7, 8'hF0, 0, 1'b0);
    // Hold off until every result so far has arrived.
    queue_req(psq_pkg::OP_POP,    0,   0, 8'h00, 0, 1'b1);
    queue_req(psq_pkg::OP_POP,    85,  5, 8'h3C, 0, 1'b0);
    queue_req(psq_pkg::OP_POP,    42,  3, 8'hC3, $urandom_range(0, MAX_GAP), 1'b0);
    queue_req(psq_pkg::OP_POP,    0,   0, 8'h00, 0, 1'b0);
    queue_req(psq_pkg::OP_POP,    0,   0, 8'h00, 0, 1'b0);
    queue_req(psq_pkg::OP_POP,    0,   0, 8'h00, $urandom_range(0, MAX_GAP), 1'b0);
    // The queue is empty again after a successful pop, so the clear flags once more.
    queue_req(psq_pkg::OP_POP,    0,   0, 8'h00, 0, 1'b0);
    queue_req(psq_pkg::OP_POP,    0,   0, 8'h00, 0, 1'b0);
    queue_req(psq_pkg::OP_INSERT, 64,  4, 8'h80, 0, 1'b0);
    queue_req(psq_pkg::OP_POP,    1,   1, 8'h01, 0, 1'b0);

    while (total < RANDOM_REQS) begin
      mode  = $urandom_range(0, 2);
      len   = $urandom_range(10, 60);
      quiet = ($urandom_range(0, 3) == 0);
      pause = ($urandom_range(0, 7) == 0);
      case (mode)
        0:       ins_pct = 80;
        1:       ins_pct = 20;
        default: ins_pct = 50;
      endcase
      for (int unsigned i = 0; i < len; i++) begin
        op = ($urandom_range(1, 100) <= ins_pct) ? psq_pkg::OP_INSERT : psq_pkg::OP_POP;
        queue_req(op, pick_importance(), pick_size(),
                  psq_pkg::TAG_W'($urandom_range(0, 255)),
                  quiet ? 0 : $urandom_range(0, MAX_GAP), pause && (i == 0));
      end
      total += len;
    end
  endtask

  // Driver: presents backlog requests, predicts each one as its transfer happens.
  always @(posedge clk_i or negedge rst_ni) begin
    pending_req_t nxt;
    bit           go;
    if (!rst_ni) begin
      start    <= 1'b0;
      req_i    <= '0;
      gap_left = 0;
    end else begin
      go = 1'b0;
      if (start && !busy) begin
        predicted_rsp_q.insert(predicted_rsp_q.size(), apply_to_shadow_queue(req_i));
        if (req_backlog_q.size() != 0) begin
          gap_left = req_backlog_q[0].gap;
        end
      end
      // No request is held, so count down the gap or launch the next one.
      if (!start || !busy) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (req_backlog_q.size() != 0 &&
                     (!req_backlog_q[0].wait_drain || predicted_rsp_q.size() == 0)) begin
          go = 1'b1;
        end
        if (go) begin
          nxt = req_backlog_q.pop_front();
          req_i <= nxt.req;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result strobe must match the oldest prediction field by field.
  always @(posedge clk_i) begin
    psq_pkg::rsp_t want;
    if (rst_ni && done_o) begin
      if (predicted_rsp_q.size() == 0) begin
        $error("result with no request waiting: status %0d", rsp_o.status);
        fail_count++;
      end else begin
        want = predicted_rsp_q.pop_front();
        if (rsp_o.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp_o.status);
          fail_count++;
        end
        if (rsp_o.out_importance !== want.out_importance) begin
          $error("out_importance: expected %0d, actual %0d",
                 want.out_importance, rsp_o.out_importance);
          fail_count++;
        end
        if (rsp_o.out_size !== want.out_size) begin
          $error("out_size: expected %0d, actual %0d", want.out_size, rsp_o.out_size);
          fail_count++;
        end
        if (rsp_o.out_tag !== want.out_tag) begin
          $error("out_tag: expected %0d, actual %0d", want.out_tag, rsp_o.out_tag);
          fail_count++;
        end
        if (rsp_o.grid_cleared !== want.grid_cleared) begin
          $error("grid_cleared: expected %0d, actual %0d",
                 want.grid_cleared, rsp_o.grid_cleared);
          fail_count++;
        end
      end
    end
  end

  // Sequence: build the stimulus, reset, then wait for everything to drain.
  initial begin
    build_stimulus();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (req_backlog_q.size() != 0 || start || predicted_rsp_q.size() != 0);
    // Let a late or spurious result show up before the verdict.
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog, well above the slowest legal run.
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
